[rtl/core/tsq_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and command/status types of the two-stack queue.
// No dependencies; every other file refers to it by scoped names.
package tsq_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;

    // request codes
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic                push;        // write input stack, bump in count
        logic                pop;         // read output stack top, drop out count
        logic                xfer;        // read input stack top, drop in count
        logic                load_rsp;    // load the result register
        logic [STATUS_W-1:0] rsp_status;
        logic                rsp_use_mem; // result data from output stack read
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_full;
        logic in_empty;
        logic out_empty;
        logic xfer_pend;  // a moved element still waits to be written
        logic rsp_free;   // result register empty or drained this cycle
    } t_dp_sts;

endpackage

[rtl/core/tsq_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the two-stack queue: request and result.
// Depends on tsq_pkg for payload widths.
interface tsq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [tsq_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface tsq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsq_pkg::DATA_W-1:0]   data;
    logic        [tsq_pkg::STATUS_W-1:0] status;
    logic        [tsq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output data, output status, output count, input ready);
    modport sink   (input valid, input data, input status, input count, output ready);
endinterface

[rtl/core/tsq_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the two-stack queue: both stack memories, their counts,
// the transfer write stage and the result register. Depends on tsq_pkg.
module tsq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsq_pkg::t_dp_cmd                    i_cmd,
    output tsq_pkg::t_dp_sts                    o_sts,
    input  logic signed [tsq_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_rsp_ready,
    output logic                                o_rsp_valid,
    output logic signed [tsq_pkg::DATA_W-1:0]   o_rsp_data,
    output logic        [tsq_pkg::STATUS_W-1:0] o_rsp_status,
    output logic        [tsq_pkg::COUNT_W-1:0]  o_rsp_count
);

    logic [tsq_pkg::CNT_W-1:0]  r_in_cnt;
    logic [tsq_pkg::CNT_W-1:0]  n_in_cnt;
    logic [tsq_pkg::CNT_W-1:0]  r_out_cnt;
    logic [tsq_pkg::CNT_W-1:0]  n_out_cnt;
    logic [tsq_pkg::CNT_W-1:0]  w_in_top;
    logic [tsq_pkg::CNT_W-1:0]  w_out_top;
    logic [tsq_pkg::CNT_W:0]    w_sum;
    logic                       r_xfer_pend;

    logic [tsq_pkg::DATA_W-1:0] r_in_mem  [tsq_pkg::STACK_DEPTH];
    logic [tsq_pkg::DATA_W-1:0] r_out_mem [tsq_pkg::STACK_DEPTH];
    logic [tsq_pkg::DATA_W-1:0] r_in_rd;
    logic [tsq_pkg::DATA_W-1:0] r_out_rd;

    logic                                r_rsp_valid;
    logic signed [tsq_pkg::DATA_W-1:0]   r_rsp_data;
    logic        [tsq_pkg::STATUS_W-1:0] r_rsp_status;
    logic        [tsq_pkg::COUNT_W-1:0]  r_rsp_count;

    assign w_in_top  = r_in_cnt - tsq_pkg::CNT_W'(1);
    assign w_out_top = r_out_cnt - tsq_pkg::CNT_W'(1);

    always_comb begin
        n_in_cnt = r_in_cnt;
        if (i_cmd.push) begin
            n_in_cnt = r_in_cnt + tsq_pkg::CNT_W'(1);
        end else if (i_cmd.xfer) begin
            n_in_cnt = w_in_top;
        end
    end

    always_comb begin
        n_out_cnt = r_out_cnt;
        if (i_cmd.pop) begin
            n_out_cnt = w_out_top;
        end else if (r_xfer_pend) begin
            n_out_cnt = r_out_cnt + tsq_pkg::CNT_W'(1);
        end
    end

    // count after this step, narrowed to the result width without loss
    assign w_sum = {1'b0, n_in_cnt} + {1'b0, n_out_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_xfer_pend <= 1'b0;
        end else begin
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_xfer_pend <= i_cmd.xfer;
        end
    end

    // input stack: push writes, transfer reads the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_in_mem[r_in_cnt[tsq_pkg::PTR_W-1:0]] <= i_value;
        end
        if (i_cmd.xfer) begin
            r_in_rd <= r_in_mem[w_in_top[tsq_pkg::PTR_W-1:0]];
        end
    end

    // output stack: the moved element lands in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (r_xfer_pend) begin
            r_out_mem[r_out_cnt[tsq_pkg::PTR_W-1:0]] <= r_in_rd;
        end
        if (i_cmd.pop) begin
            r_out_rd <= r_out_mem[w_out_top[tsq_pkg::PTR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.load_rsp) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp_data   <= i_cmd.rsp_use_mem ? $signed(r_out_rd) : '0;
            r_rsp_status <= i_cmd.rsp_status;
            r_rsp_count  <= tsq_pkg::COUNT_W'(w_sum);
        end
    end

    assign o_sts.in_full   = (r_in_cnt == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH));
    assign o_sts.in_empty  = (r_in_cnt == '0);
    assign o_sts.out_empty = (r_out_cnt == '0);
    assign o_sts.xfer_pend = r_xfer_pend;
    assign o_sts.rsp_free  = !r_rsp_valid || i_rsp_ready;

    assign o_rsp_valid  = r_rsp_valid;
    assign o_rsp_data   = r_rsp_data;
    assign o_rsp_status = r_rsp_status;
    assign o_rsp_count  = r_rsp_count;

endmodule

[rtl/core/tsq_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the two-stack queue: decodes requests and sequences the
// stack transfer and pop. Depends on tsq_pkg.
module tsq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_type,
    output logic             o_req_ready,
    input  tsq_pkg::t_dp_sts i_sts,
    output tsq_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_XFER = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_req_ready = (r_state == S_IDLE) && i_sts.rsp_free;
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.rsp_status = tsq_pkg::STS_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == tsq_pkg::REQ_ENQ) begin
                        o_cmd.load_rsp = 1'b1;
                        if (i_sts.in_full) begin
                            o_cmd.rsp_status = tsq_pkg::STS_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_sts.in_empty && i_sts.out_empty) begin
                        o_cmd.load_rsp   = 1'b1;
                        o_cmd.rsp_status = tsq_pkg::STS_EMPTY;
                    end else if (!i_sts.out_empty) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_POP;
                    end else begin
                        n_state = S_XFER;
                    end
                end
            end
            S_XFER: begin
                // move one element a cycle; pop once the last write has landed
                if (!i_sts.in_empty) begin
                    o_cmd.xfer = 1'b1;
                end else if (!i_sts.xfer_pend) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP;
                end
            end
            S_POP: begin
                o_cmd.load_rsp    = 1'b1;
                o_cmd.rsp_use_mem = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/two_stack_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the two-stack queue: controller plus datapath behind
// valid/ready request and result channels. Depends on tsq_pkg and tsq_if.

// First-in first-out queue of 32-bit values held in two stacks of
// STACK_DEPTH entries. Each request beat gives one result beat with data,
// status and the element count after the step. An enqueue, or any refused
// request, yields its result in the cycle after acceptance; a dequeue served
// from a non-empty output stack reads the stack memory into a register and
// then loads the result register. A dequeue that finds the output stack
// empty first moves the N elements of the input stack over, one memory read
// and one write per cycle, and pops once the last write lands. A new request
// is taken only while the result register is empty or its beat is taken
// in the same cycle, so a stalled result holds off the request channel.
module two_stack_queue_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsq_req_if.sink   i_req,
    tsq_rsp_if.source o_rsp
);

    tsq_pkg::t_dp_cmd w_cmd;
    tsq_pkg::t_dp_sts w_sts;

    tsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tsq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_req.value),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp_data   (o_rsp.data),
        .o_rsp_status (o_rsp.status),
        .o_rsp_count  (o_rsp.count)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !w_sts.in_full)
        else $error("push onto full input stack");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_sts.out_empty && !w_sts.xfer_pend)
        else $error("pop from empty or unsettled output stack");

    a_rsp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_rsp |-> w_sts.rsp_free)
        else $error("result register overwritten before it was taken");

    a_xfer_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.xfer |-> !w_cmd.push && !w_cmd.pop && !w_cmd.load_rsp)
        else $error("transfer overlaps another stack operation");

endmodule

[tb/tb_two_stack_queue_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the two-stack queue: random request and result stalls,
// a predictor of the two stacks, and an in-order check of every result beat.
// Depends on tsq_pkg, tsq_if and two_stack_queue_top.

typedef struct packed {
    logic signed [tsq_pkg::DATA_W-1:0]   data;
    logic        [tsq_pkg::STATUS_W-1:0] status;
    logic        [tsq_pkg::COUNT_W-1:0]  count;
} t_tsq_result;

class tsq_scoreboard;
    logic [tsq_pkg::DATA_W-1:0] push_side[tsq_pkg::STACK_DEPTH];
    logic [tsq_pkg::DATA_W-1:0] pop_side[tsq_pkg::STACK_DEPTH];
    int unsigned                push_cnt;
    int unsigned                pop_cnt;
    t_tsq_result                pending_q[$];
    int unsigned                n_errors;

    function new();
        push_cnt  = 0;
        pop_cnt   = 0;
        n_errors  = 0;
    endfunction

    function void flag(string what, longint exp_v, longint act_v);
        n_errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    // Advance the stack pair by one accepted request and queue its result.
    function void note_request(logic rt, logic signed [tsq_pkg::DATA_W-1:0] v);
        t_tsq_result r;
        int unsigned total;
        r.data   = '0;
        r.status = tsq_pkg::STS_OK;
        if (rt == tsq_pkg::REQ_ENQ) begin
            if (push_cnt >= tsq_pkg::STACK_DEPTH) begin
                r.status = tsq_pkg::STS_FULL;
            end else begin
                push_side[push_cnt] = v;
                push_cnt++;
            end
        end else if (push_cnt == 0 && pop_cnt == 0) begin
            r.status = tsq_pkg::STS_EMPTY;
        end else begin
            // refill reverses the order so the oldest element lands on top
            if (pop_cnt == 0) begin
                while (push_cnt > 0 && pop_cnt < tsq_pkg::STACK_DEPTH) begin
                    push_cnt--;
                    pop_side[pop_cnt] = push_side[push_cnt];
                    pop_cnt++;
                end
            end
            pop_cnt--;
            r.data = pop_side[pop_cnt];
        end
        total   = push_cnt + pop_cnt;
        r.count = total[tsq_pkg::COUNT_W-1:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [tsq_pkg::DATA_W-1:0] d,
                               logic [tsq_pkg::STATUS_W-1:0] s,
                               logic [tsq_pkg::COUNT_W-1:0] c);
        t_tsq_result e;
        if (pending_q.size() == 0) begin
            n_errors++;
            $display("%0t ns: unexpected result beat, expected none,", $time,
                     " actual data %0d status %0d count %0d", d, s, c);
            return;
        end
        e = pending_q.pop_front();
        if (d !== e.data)   flag("data", e.data, d);
        if (s !== e.status) flag("status", e.status, s);
        if (c !== e.count)  flag("count", e.count, c);
    endfunction
endclass

module tb_two_stack_queue_top;

    localparam int N_ITEMS     = 1700;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 40;

    logic i_clk;
    logic i_rst_n;

    tsq_req_if req_ch ();
    tsq_rsp_if rsp_ch ();

    two_stack_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tsq_scoreboard queue_model;
    int            n_sent;
    bit            tx_no_idle;
    bit            rx_no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("[two_stack_queue_top] ERROR");
        $finish;
    end

    function automatic logic signed [tsq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request beat after a random gap and hold it until taken.
    task automatic send_beat(input logic rt, input logic signed [tsq_pkg::DATA_W-1:0] v);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.value    <= v;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        queue_model.note_request(rt, v);
        n_sent++;
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial begin
        int stall;
        int n_seen;
        n_seen       = 0;
        rsp_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = rx_no_idle ? 0 : $urandom_range(0, 6);
            if (n_seen == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            queue_model.check_result(rsp_ch.data, rsp_ch.status, rsp_ch.count);
            n_seen++;
        end
    end

    initial begin
        int seg_len;
        int enq_pct;
        queue_model     = new();
        n_sent          = 0;
        tx_no_idle      = 1'b0;
        rx_no_idle      = 1'b0;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = tsq_pkg::REQ_ENQ;
        req_ch.value    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dequeue, field extremes, refill in the middle
        send_beat(tsq_pkg::REQ_DEQ, 32'sh7FFF_FFFF);
        send_beat(tsq_pkg::REQ_ENQ, 32'sh8000_0000);
        send_beat(tsq_pkg::REQ_ENQ, 32'sh7FFF_FFFF);
        send_beat(tsq_pkg::REQ_ENQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_ENQ, -32'sd1);
        send_beat(tsq_pkg::REQ_ENQ, 32'sh5555_5555);
        send_beat(tsq_pkg::REQ_ENQ, 32'shAAAA_AAAA);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_DEQ, -32'sd1);
        send_beat(tsq_pkg::REQ_ENQ, 32'sd1);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh1234_5678);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);
        send_beat(tsq_pkg::REQ_DEQ, 32'sh0000_0000);

        // fill the input stack past full, move it over, fill again while
        // the output stack still has room, then drain past empty
        repeat (tsq_pkg::STACK_DEPTH + 1) send_beat(tsq_pkg::REQ_ENQ, pick_value());
        send_beat(tsq_pkg::REQ_DEQ, pick_value());
        repeat (tsq_pkg::STACK_DEPTH + 1) send_beat(tsq_pkg::REQ_ENQ, pick_value());
        repeat (2 * tsq_pkg::STACK_DEPTH + 1) send_beat(tsq_pkg::REQ_DEQ, pick_value());

        // random segments biased toward growth, balance or drain
        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            seg_len    = $urandom_range(30, 150);
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    send_beat(tsq_pkg::REQ_ENQ, pick_value());
                else
                    send_beat(tsq_pkg::REQ_DEQ, pick_value());
            end
        end
        req_ch.valid <= 1'b0;

        while (queue_model.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (queue_model.n_errors == 0)
            $display("[two_stack_queue_top] OK");
        else
            $display("[two_stack_queue_top] ERROR");
        $finish;
    end
endmodule

[two_stack_queue_top.f]
rtl/core/tsq_pkg.sv
rtl/core/tsq_if.sv
rtl/core/tsq_datapath.sv
rtl/core/tsq_ctrl.sv
rtl/core/two_stack_queue_top.sv
tb/tb_two_stack_queue_top.sv
